[rtl/core/flight_circling_glide_detector_assert.svh]
// assertion macros used by the flight circling and glide detector core rtl
`ifndef FLIGHT_CIRCLING_GLIDE_DETECTOR_ASSERT_SVH
`define FLIGHT_CIRCLING_GLIDE_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle check, off while in reset
`define FCGD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("fcgd assertion failed: %m");
// next-cycle check after a trigger, off while in reset
`define FCGD_ASSERT_NEXT(lbl, trig, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error("fcgd assertion failed: %m");
`else
`define FCGD_ASSERT(lbl, prop)
`define FCGD_ASSERT_NEXT(lbl, trig, prop)
`endif
`endif

[rtl/core/fcgd_pkg.sv]
// types, codes and constants of the flight circling and glide detector
`timescale 1ns / 1ps
package fcgd_pkg;

  // stream and config port widths
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 184;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // flight mode codes
  localparam logic [2:0] MODE_WAITING  = 3'd0;
  localparam logic [2:0] MODE_READY    = 3'd1;
  localparam logic [2:0] MODE_FLYING   = 3'd2;
  localparam logic [2:0] MODE_CIRCLING = 3'd3;
  localparam logic [2:0] MODE_GLIDING  = 3'd4;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAKEOFF_SPEED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LANDING_SPEED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LANDING_TIMEOUT = 2'd2;

  // config reset values
  localparam logic [15:0] TAKEOFF_SPEED_RST   = 16'd100;
  localparam logic [15:0] LANDING_SPEED_RST   = 16'd50;
  localparam logic [31:0] LANDING_TIMEOUT_RST = 32'd10000;

  // turn and mode thresholds
  localparam int HDG_WRAP           = 180;
  localparam int FULL_TURN          = 360;
  localparam int TURN_CLAMP         = 450;
  localparam int CIRCLE_TRIGGER     = 360;
  localparam int STRAIGHT_MAX       = 10;
  localparam int STRAIGHT_THRESHOLD = 6;
  localparam int GLIDE_START        = 6;
  localparam int GLIDE_EXIT         = 6;
  localparam int CIRCLE_EXIT        = 3;
  localparam int MIN_THERMAL_GAIN   = 10;
  localparam int GAIN_MAX           = 16383;
  localparam int GAIN_MIN           = -16384;

  // one gps fix
  typedef struct packed {
    logic        [8:0]  heading_deg;
    logic        [15:0] ground_speed;
    logic signed [14:0] gps_altitude_m;
    logic signed [11:0] climb_rate_cms;
    logic        [31:0] utc_seconds;
    logic        [31:0] now_ms;
  } fix_t;

  // config register set
  typedef struct packed {
    logic [15:0] takeoff_speed;
    logic [15:0] landing_speed;
    logic [31:0] landing_timeout_ms;
  } cfg_t;

  // one result
  typedef struct packed {
    logic        [2:0]  flight_mode;
    logic signed [9:0]  turn_sum_deg;
    logic        [3:0]  straight_count;
    logic        [15:0] thermal_count;
    logic signed [14:0] best_thermal_gain_m;
    logic signed [14:0] altitude_max_m;
    logic signed [14:0] altitude_min_m;
    logic signed [11:0] climb_max_cms;
    logic signed [11:0] climb_min_cms;
    logic        [31:0] flight_time_s;
    logic        [31:0] circling_time_s;
    logic signed [14:0] circling_gain_m;
  } result_t;

endpackage

[rtl/core/fcgd_in_stage.sv]
// input register stage: takes a fix request and holds it for the update
`timescale 1ns / 1ps
module fcgd_in_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // heading_deg, ground_speed, gps_altitude_m, climb_rate_cms, utc_seconds, now_ms
  input  logic [fcgd_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                           advance,
  output logic                           valid,
  output fcgd_pkg::fix_t                 fix
);
  import fcgd_pkg::*;

  logic valid_r, valid_nxt;
  fix_t fix_r;
  logic take;

  // free slot or slot drains this cycle
  assign in_tready = !valid_r || advance;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // unpack fields, first field in the low bits
  always_ff @(posedge clk) begin
    if (take) begin
      fix_r.heading_deg    <= in_tdata[8:0];
      fix_r.ground_speed   <= in_tdata[24:9];
      fix_r.gps_altitude_m <= in_tdata[39:25];
      fix_r.climb_rate_cms <= in_tdata[51:40];
      fix_r.utc_seconds    <= in_tdata[83:52];
      fix_r.now_ms         <= in_tdata[115:84];
    end
  end

  assign valid = valid_r;
  assign fix   = fix_r;

endmodule

[rtl/core/fcgd_core.sv]
// flight state registers and their single-step update
`timescale 1ns / 1ps
`include "flight_circling_glide_detector_assert.svh"
module fcgd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  fcgd_pkg::fix_t    fix,
  input  fcgd_pkg::cfg_t    cfg,
  output fcgd_pkg::result_t res
);
  import fcgd_pkg::*;

  // state
  logic        [2:0]  mode_r, mode_nxt;
  logic        [8:0]  prev_hdg_r;
  logic signed [9:0]  turn_r, turn_nxt;
  logic        [3:0]  straight_r, straight_nxt;
  logic        [31:0] takeoff_r, takeoff_nxt;
  logic        [31:0] slow_r, slow_nxt;
  logic        [31:0] cstart_t_r, cstart_t_nxt;
  logic signed [14:0] cstart_alt_r, cstart_alt_nxt;
  logic        [31:0] ctime_r, ctime_nxt;
  logic signed [14:0] cgain_r, cgain_nxt;
  logic        [15:0] thermals_r, thermals_nxt;
  logic signed [14:0] best_r, best_nxt;
  logic signed [14:0] alt_hi_r, alt_hi_nxt;
  logic signed [14:0] alt_lo_r, alt_lo_nxt;
  logic signed [11:0] climb_hi_r, climb_hi_nxt;
  logic signed [11:0] climb_lo_r, climb_lo_nxt;
  logic        [31:0] ftime_r, ftime_nxt;

  // datapath temporaries
  logic signed [9:0]  delta_raw;
  logic signed [9:0]  delta;
  logic signed [10:0] turn_wide;
  logic signed [9:0]  turn_upd;
  logic        [7:0]  turn_mag;
  logic        [8:0]  turn_abs;
  logic        [3:0]  straight_upd;
  logic signed [15:0] gain_wide;
  logic signed [14:0] gain_sat;
  logic        [31:0] ctime_upd;
  logic        [31:0] slow_elapsed;

  // heading change wrapped once each way
  always_comb begin
    delta_raw = $signed({1'b0, fix.heading_deg}) - $signed({1'b0, prev_hdg_r});
    delta     = delta_raw;
    if (delta_raw > HDG_WRAP) begin
      delta = delta_raw - 10'(FULL_TURN);
    end else if (delta_raw < -HDG_WRAP) begin
      delta = delta_raw + 10'(FULL_TURN);
    end
  end

  // clamped turn sum and straight counter step
  always_comb begin
    turn_wide = 11'(turn_r) + 11'(delta);
    if (turn_wide > TURN_CLAMP) begin
      turn_upd = 10'(TURN_CLAMP);
    end else if (turn_wide < -TURN_CLAMP) begin
      turn_upd = 10'(-TURN_CLAMP);
    end else begin
      turn_upd = turn_wide[9:0];
    end
    turn_mag = (delta < 0) ? 8'(-delta) : 8'(delta);
    turn_abs = (turn_upd < 0) ? 9'(-turn_upd) : 9'(turn_upd);
    straight_upd = straight_r;
    if (turn_mag < STRAIGHT_THRESHOLD) begin
      if (straight_r < STRAIGHT_MAX) begin
        straight_upd = straight_r + 4'd1;
      end
    end else if (straight_r != 4'd0) begin
      straight_upd = straight_r - 4'd1;
    end
  end

  // circling gain and time
  always_comb begin
    gain_wide = 16'(fix.gps_altitude_m) - 16'(cstart_alt_r);
    if (gain_wide > GAIN_MAX) begin
      gain_sat = 15'(GAIN_MAX);
    end else if (gain_wide < GAIN_MIN) begin
      gain_sat = 15'(GAIN_MIN);
    end else begin
      gain_sat = gain_wide[14:0];
    end
    ctime_upd    = fix.utc_seconds - cstart_t_r;
    slow_elapsed = fix.now_ms - slow_r;
  end

  // mode sequencing and statistics
  always_comb begin
    mode_nxt       = mode_r;
    turn_nxt       = turn_r;
    straight_nxt   = straight_r;
    takeoff_nxt    = takeoff_r;
    slow_nxt       = slow_r;
    cstart_t_nxt   = cstart_t_r;
    cstart_alt_nxt = cstart_alt_r;
    ctime_nxt      = ctime_r;
    cgain_nxt      = cgain_r;
    thermals_nxt   = thermals_r;
    best_nxt       = best_r;
    alt_hi_nxt     = alt_hi_r;
    alt_lo_nxt     = alt_lo_r;
    climb_hi_nxt   = climb_hi_r;
    climb_lo_nxt   = climb_lo_r;
    ftime_nxt      = ftime_r;
    unique case (mode_r)
      MODE_WAITING: begin
        mode_nxt = MODE_READY;
      end
      MODE_READY: begin
        // takeoff: clear flight statistics
        if (fix.ground_speed > cfg.takeoff_speed) begin
          turn_nxt       = '0;
          straight_nxt   = '0;
          cstart_t_nxt   = '0;
          cstart_alt_nxt = '0;
          ctime_nxt      = '0;
          cgain_nxt      = '0;
          thermals_nxt   = '0;
          best_nxt       = '0;
          climb_hi_nxt   = '0;
          climb_lo_nxt   = '0;
          ftime_nxt      = '0;
          takeoff_nxt    = fix.utc_seconds;
          alt_hi_nxt     = fix.gps_altitude_m;
          alt_lo_nxt     = fix.gps_altitude_m;
          slow_nxt       = fix.now_ms;
          mode_nxt       = MODE_FLYING;
        end
      end
      default: begin
        // in flight: extremes, turn tracking, mode change
        ftime_nxt = fix.utc_seconds - takeoff_r;
        if (fix.gps_altitude_m > alt_hi_r) alt_hi_nxt = fix.gps_altitude_m;
        if (fix.gps_altitude_m < alt_lo_r) alt_lo_nxt = fix.gps_altitude_m;
        if (fix.climb_rate_cms > climb_hi_r) climb_hi_nxt = fix.climb_rate_cms;
        if (fix.climb_rate_cms < climb_lo_r) climb_lo_nxt = fix.climb_rate_cms;
        turn_nxt     = turn_upd;
        straight_nxt = straight_upd;
        if (mode_r == MODE_FLYING) begin
          if (turn_abs > CIRCLE_TRIGGER) begin
            mode_nxt       = MODE_CIRCLING;
            cstart_t_nxt   = fix.utc_seconds;
            cstart_alt_nxt = fix.gps_altitude_m;
            ctime_nxt      = '0;
            cgain_nxt      = '0;
            straight_nxt   = '0;
          end else if (straight_upd > GLIDE_START) begin
            mode_nxt = MODE_GLIDING;
          end
        end else if (mode_r == MODE_CIRCLING) begin
          ctime_nxt = ctime_upd;
          cgain_nxt = gain_sat;
          if (straight_upd > CIRCLE_EXIT) begin
            mode_nxt = MODE_FLYING;
            // thermal counts only with real gain and nonzero duration
            if (gain_sat > MIN_THERMAL_GAIN && ctime_upd != 32'd0) begin
              if (thermals_r != 16'hFFFF) thermals_nxt = thermals_r + 16'd1;
              if (gain_sat > best_r) best_nxt = gain_sat;
            end
            turn_nxt = '0;
          end
        end else if (mode_r == MODE_GLIDING) begin
          if (straight_upd < GLIDE_EXIT) mode_nxt = MODE_FLYING;
        end
        // landing check after the flight update
        if (fix.ground_speed < cfg.landing_speed) begin
          if (slow_elapsed > cfg.landing_timeout_ms) mode_nxt = MODE_READY;
        end else begin
          slow_nxt = fix.now_ms;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_WAITING;
      prev_hdg_r   <= '0;
      turn_r       <= '0;
      straight_r   <= '0;
      takeoff_r    <= '0;
      slow_r       <= '0;
      cstart_t_r   <= '0;
      cstart_alt_r <= '0;
      ctime_r      <= '0;
      cgain_r      <= '0;
      thermals_r   <= '0;
      best_r       <= '0;
      alt_hi_r     <= '0;
      alt_lo_r     <= '0;
      climb_hi_r   <= '0;
      climb_lo_r   <= '0;
      ftime_r      <= '0;
    end else if (step) begin
      mode_r       <= mode_nxt;
      prev_hdg_r   <= fix.heading_deg;
      turn_r       <= turn_nxt;
      straight_r   <= straight_nxt;
      takeoff_r    <= takeoff_nxt;
      slow_r       <= slow_nxt;
      cstart_t_r   <= cstart_t_nxt;
      cstart_alt_r <= cstart_alt_nxt;
      ctime_r      <= ctime_nxt;
      cgain_r      <= cgain_nxt;
      thermals_r   <= thermals_nxt;
      best_r       <= best_nxt;
      alt_hi_r     <= alt_hi_nxt;
      alt_lo_r     <= alt_lo_nxt;
      climb_hi_r   <= climb_hi_nxt;
      climb_lo_r   <= climb_lo_nxt;
      ftime_r      <= ftime_nxt;
    end
  end

  // result shows the state after this fix
  always_comb begin
    res.flight_mode         = mode_nxt;
    res.turn_sum_deg        = turn_nxt;
    res.straight_count      = straight_nxt;
    res.thermal_count       = thermals_nxt;
    res.best_thermal_gain_m = best_nxt;
    res.altitude_max_m      = alt_hi_nxt;
    res.altitude_min_m      = alt_lo_nxt;
    res.climb_max_cms       = climb_hi_nxt;
    res.climb_min_cms       = climb_lo_nxt;
    res.flight_time_s       = ftime_nxt;
    res.circling_time_s     = ctime_nxt;
    res.circling_gain_m     = cgain_nxt;
  end

  // first fix only arms the block
  `FCGD_ASSERT_NEXT(a_wait_to_ready, mode_r == MODE_WAITING,
                    mode_r == MODE_WAITING || mode_r == MODE_READY)
  // altitude extremes stay ordered while in flight
  `FCGD_ASSERT(a_alt_order,
               !(mode_r == MODE_FLYING || mode_r == MODE_CIRCLING || mode_r == MODE_GLIDING)
               || (alt_lo_r <= alt_hi_r))
  // circling entry restarts the counter and circle statistics
  `FCGD_ASSERT_NEXT(a_circle_entry,
                    step && mode_r == MODE_FLYING && mode_nxt == MODE_CIRCLING,
                    straight_r == 4'd0 && ctime_r == 32'd0 && cgain_r == 15'sd0)
  // thermal count never drops while in flight
  `FCGD_ASSERT_NEXT(a_thermals_mono,
                    step && mode_r != MODE_READY && mode_r != MODE_WAITING,
                    thermals_r >= $past(thermals_r))

endmodule

[rtl/core/fcgd_out_stage.sv]
// result register: packs a result and holds it until taken
`timescale 1ns / 1ps
module fcgd_out_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  fcgd_pkg::result_t               res,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // flight_mode, turn_sum_deg, straight_count, thermal_count, best_thermal_gain_m,
  // altitude_max_m, altitude_min_m, climb_max_cms, climb_min_cms, flight_time_s,
  // circling_time_s, circling_gain_m
  output logic [fcgd_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import fcgd_pkg::*;

  logic                   valid_r, valid_nxt;
  logic [OUT_TDATA_W-1:0] data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // pack fields, first field in the low bits, zero pad on top
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {3'b000, res.circling_gain_m, res.circling_time_s, res.flight_time_s,
                 res.climb_min_cms, res.climb_max_cms, res.altitude_min_m,
                 res.altitude_max_m, res.best_thermal_gain_m, res.thermal_count,
                 res.straight_count, res.turn_sum_deg, res.flight_mode};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

[rtl/core/flight_circling_glide_detector.sv]
// top level of the flight circling and glide detector
// a fix request is registered in the input stage, then its result in the result register
// throughput: one fix per cycle while the result register is not stalled;
// a stalled result register holds the input stage until out_tready rises
// reset: synchronous active-low rst_n clears mode to waiting, all statistics
// to zero and the config registers to their defaults
`timescale 1ns / 1ps
module flight_circling_glide_detector (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // heading_deg, ground_speed, gps_altitude_m, climb_rate_cms, utc_seconds, now_ms
  input  logic [fcgd_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // flight_mode, turn_sum_deg, straight_count, thermal_count, best_thermal_gain_m,
  // altitude_max_m, altitude_min_m, climb_max_cms, climb_min_cms, flight_time_s,
  // circling_time_s, circling_gain_m
  output logic [fcgd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [fcgd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcgd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import fcgd_pkg::*;

  cfg_t    cfg_r;
  logic    s1_valid;
  fix_t    s1_fix;
  logic    step;
  result_t res;

  // config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.takeoff_speed      <= TAKEOFF_SPEED_RST;
      cfg_r.landing_speed      <= LANDING_SPEED_RST;
      cfg_r.landing_timeout_ms <= LANDING_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TAKEOFF_SPEED:   cfg_r.takeoff_speed      <= cfg_wdata[15:0];
        CFG_LANDING_SPEED:   cfg_r.landing_speed      <= cfg_wdata[15:0];
        CFG_LANDING_TIMEOUT: cfg_r.landing_timeout_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a held fix moves on when the result register is free or draining
  assign step = s1_valid && (!out_tvalid || out_tready);

  fcgd_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .advance   (step),
    .valid     (s1_valid),
    .fix       (s1_fix)
  );

  fcgd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .fix   (s1_fix),
    .cfg   (cfg_r),
    .res   (res)
  );

  fcgd_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
